>>> rtl/tbp_pkg.sv
`timescale 1ns / 1ps
package tbp_pkg;

  localparam int GLOBAL_HIST_BITS   = 15;
  localparam int LOCAL_HIST_BITS    = 6;
  localparam int LOCAL_HIST_ENTRIES = 512;
  localparam int LOCAL_SETS         = 8;
  localparam int CHOICE_ENTRIES     = 4096;

  localparam int PC_W          = 15;
  localparam int GLOBAL_ENTRIES = 1 << GLOBAL_HIST_BITS;
  localparam int LOCAL_PATTERNS = 1 << LOCAL_HIST_BITS;
  localparam int LOCAL_CTRS     = LOCAL_SETS * LOCAL_PATTERNS;
  localparam int SET_W          = $clog2(LOCAL_SETS);
  localparam int LH_IDX_W       = $clog2(LOCAL_HIST_ENTRIES);
  localparam int LC_IDX_W       = $clog2(LOCAL_CTRS);
  localparam int CH_IDX_W       = $clog2(CHOICE_ENTRIES);

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  localparam int CLR_DEPTH = max2(max2(GLOBAL_ENTRIES, CHOICE_ENTRIES),
                                  max2(LOCAL_CTRS, LOCAL_HIST_ENTRIES));
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  // request codes
  localparam logic REQ_PREDICT = 1'b0;
  localparam logic REQ_UPDATE  = 1'b1;

  localparam logic [1:0] CTR_MAX        = 2'd3;
  localparam logic [1:0] CTR_MIN        = 2'd0;
  localparam logic [1:0] LOCAL_CTR_INIT = 2'd1;

  typedef struct packed {
    logic       tag;
    logic [1:0] ctr;
  } global_entry_t;

  function automatic logic [1:0] sat_up(input logic [1:0] c);
    return (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
  endfunction

  function automatic logic [1:0] sat_down(input logic [1:0] c);
    return (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
  endfunction

endpackage

>>> rtl/tbp_ram.sv
`timescale 1ns / 1ps
module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tournament_branch_predictor.sv
`timescale 1ns / 1ps
// tournament branch predictor: local two-level side, global side, choice table
//
// input channel: an item is taken when start is high and busy is low. in_req_type
// selects a prediction request or an update (resolved outcome plus the direction
// that was predicted earlier for that branch).
// result channel: a prediction request gives one result, out_valid high for one
// cycle with out_predict_taken. an update gives no result. the receiver cannot
// stall, so a result is simply dropped onto the ports.
// a prediction passes S_RD1 and S_RD2; out_valid is registered from S_RD2.
// the block takes no new item until the last is through: busy stays high in S_RD1
// and S_RD2 after each transfer, for the two dependent memory reads (local history,
// then the local counter it selects).
// reset: all tables live in single-port-write synchronous rams. after reset a
// clearing pass writes every entry, one address per cycle over 32768 addresses
// (the largest table), with busy held high; global history is cleared at once.
module tournament_branch_predictor (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_req_type,
  input  logic [tbp_pkg::PC_W-1:0] in_pc,
  input  logic                   in_resolved_taken,
  input  logic                   in_earlier_prediction,
  output logic                   out_valid,
  output logic                   out_predict_taken
);
  import tbp_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_RD1   = 4'b0100,
    S_RD2   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [CLR_W-1:0] clr_cnt_r;

  logic [GLOBAL_HIST_BITS-1:0] gh_r;
  logic                        req_r, taken_r, earlier_r;
  logic [31:0]                 pc_ext;
  logic [31:0]                 pc_r_ext;
  logic [PC_W-1:0]             pc_r;
  logic [LOCAL_HIST_BITS-1:0]  hist_r;
  logic [LC_IDX_W-1:0]         lslot_r;
  logic [GLOBAL_HIST_BITS-1:0] gidx_r;
  logic                        out_valid_r, out_taken_r;

  logic                        accept;
  logic                        clearing;

  // ram ports
  logic                        lh_we, lc_we, gm_we, ch_we;
  logic [LH_IDX_W-1:0]         lh_waddr, lh_raddr;
  logic [LOCAL_HIST_BITS-1:0]  lh_wdata, lh_rdata;
  logic [LC_IDX_W-1:0]         lc_waddr, lc_raddr;
  logic [1:0]                  lc_wdata, lc_rdata;
  logic [GLOBAL_HIST_BITS-1:0] gm_waddr, gm_raddr;
  global_entry_t               gm_wdata, gm_rdata;
  logic [CH_IDX_W-1:0]         ch_waddr, ch_raddr;
  logic [1:0]                  ch_wdata, ch_rdata;

  logic                        do_update;
  logic                        correct;
  logic [LC_IDX_W-1:0]         lslot_rd1;

  assign accept   = start && (state_r == S_IDLE);
  assign clearing = (state_r == S_CLEAR);
  assign busy     = (state_r != S_IDLE);

  assign pc_ext   = {{(32-PC_W){1'b0}}, in_pc};
  assign pc_r_ext = {{(32-PC_W){1'b0}}, pc_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_cnt_r == CLR_W'(CLR_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_RD1;
      S_RD1:   state_nxt = S_RD2;
      S_RD2:   state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      gh_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_RD2) && (req_r == REQ_PREDICT);
      if (clearing) begin
        clr_cnt_r <= clr_cnt_r + CLR_W'(1);
      end
      if (do_update) begin
        gh_r <= {gh_r[GLOBAL_HIST_BITS-2:0], taken_r};
      end
    end
  end

  // item capture and stage registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r     <= in_req_type;
      pc_r      <= in_pc;
      taken_r   <= in_resolved_taken;
      earlier_r <= in_earlier_prediction;
      gidx_r    <= gh_r ^ pc_ext[GLOBAL_HIST_BITS-1:0];
    end
    if (state_r == S_RD1) begin
      hist_r  <= lh_rdata;
      lslot_r <= lslot_rd1;
    end
    if (state_r == S_RD2) begin
      out_taken_r <= (!ch_rdata[1] && gm_rdata.tag) ? gm_rdata.ctr[1] : lc_rdata[1];
    end
  end

  assign lslot_rd1 = {pc_r_ext[SET_W-1:0], lh_rdata};

  // read addresses: from the ports on the transfer cycle, held from the capture after
  always_comb begin
    if (state_r == S_IDLE) begin
      lh_raddr = pc_ext[SET_W +: LH_IDX_W];
      gm_raddr = gh_r ^ pc_ext[GLOBAL_HIST_BITS-1:0];
      ch_raddr = pc_ext[CH_IDX_W-1:0];
    end else begin
      lh_raddr = pc_r_ext[SET_W +: LH_IDX_W];
      gm_raddr = gidx_r;
      ch_raddr = pc_r_ext[CH_IDX_W-1:0];
    end
    lc_raddr = (state_r == S_RD1) ? lslot_rd1 : lslot_r;
  end

  assign do_update = (state_r == S_RD2) && (req_r == REQ_UPDATE);
  assign correct   = (earlier_r == taken_r);

  always_comb begin
    lh_we = clearing || do_update;
    lc_we = clearing || do_update;
    gm_we = clearing || do_update;
    ch_we = clearing || do_update;
    if (clearing) begin
      lh_waddr = clr_cnt_r[LH_IDX_W-1:0];
      lh_wdata = '0;
      lc_waddr = clr_cnt_r[LC_IDX_W-1:0];
      lc_wdata = LOCAL_CTR_INIT;
      gm_waddr = clr_cnt_r[GLOBAL_HIST_BITS-1:0];
      gm_wdata = '0;
      ch_waddr = clr_cnt_r[CH_IDX_W-1:0];
      ch_wdata = CTR_MIN;
    end else begin
      lh_waddr = pc_r_ext[SET_W +: LH_IDX_W];
      lh_wdata = {hist_r[LOCAL_HIST_BITS-2:0], taken_r};
      lc_waddr = lslot_r;
      lc_wdata = taken_r ? sat_up(lc_rdata) : sat_down(lc_rdata);
      gm_waddr = gidx_r;
      gm_wdata.ctr = taken_r ? sat_up(gm_rdata.ctr) : sat_down(gm_rdata.ctr);
      // tag is set once global was trusted and right
      gm_wdata.tag = gm_rdata.tag || (correct && !ch_rdata[1]);
      ch_waddr = pc_r_ext[CH_IDX_W-1:0];
      // msb set: right counts up; msb clear: right counts down
      ch_wdata = (correct == ch_rdata[1]) ? sat_up(ch_rdata) : sat_down(ch_rdata);
    end
  end

  tbp_ram #(.WIDTH(LOCAL_HIST_BITS), .DEPTH(LOCAL_HIST_ENTRIES)) u_local_hist (
    .clk(clk), .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata),
    .raddr(lh_raddr), .rdata(lh_rdata)
  );

  tbp_ram #(.WIDTH(2), .DEPTH(LOCAL_CTRS)) u_local_ctr (
    .clk(clk), .we(lc_we), .waddr(lc_waddr), .wdata(lc_wdata),
    .raddr(lc_raddr), .rdata(lc_rdata)
  );

  tbp_ram #(.WIDTH($bits(global_entry_t)), .DEPTH(GLOBAL_ENTRIES)) u_global (
    .clk(clk), .we(gm_we), .waddr(gm_waddr), .wdata(gm_wdata),
    .raddr(gm_raddr), .rdata(gm_rdata)
  );

  tbp_ram #(.WIDTH(2), .DEPTH(CHOICE_ENTRIES)) u_choice (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(ch_raddr), .rdata(ch_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_predict_taken = out_taken_r;

endmodule

>>> rtl/tbp_checker.sv
`timescale 1ns / 1ps
module tbp_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_req_type,
  input logic out_valid
);
  import tbp_pkg::*;

  // a prediction transfer gives its result once S_RD1 and S_RD2 have passed
  a_predict_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == REQ_PREDICT) |-> ##3 out_valid)
    else $error("prediction result missing");

  // an update transfer never gives a result
  a_update_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == REQ_UPDATE) |-> ##3 !out_valid)
    else $error("result after update");

  // an item holds the block busy through the read states after its transfer
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy ##1 busy)
    else $error("busy dropped early");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .in_req_type(in_req_type),
  .out_valid(out_valid)
);
